FILE: design/dead_reckoning_pose_update_macros.svh
// Assertion helpers for the pose update block.
`ifndef DEAD_RECKONING_POSE_UPDATE_MACROS_SVH
`define DEAD_RECKONING_POSE_UPDATE_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define DRPU_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define DRPU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/drpu_pkg.sv
`default_nettype none

package drpu_pkg;

  // operation codes
  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_TURN = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_ITER = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IDX_W = $clog2(NUM_ITER);
  localparam int ATAN_IDX_W = 5;

  // gain compensation 0.60725..., Q0.32, split for two 32x17 products
  localparam logic [15:0] GAIN_HI = 16'h9B74;
  localparam logic [15:0] GAIN_LO = 16'hEDA8;

  localparam int VEC_W   = 50;  // CORDIC vector, 32 fraction bits
  localparam int ANG_W   = 26;  // angle accumulator, 2^24 per turn
  localparam int DELTA_W = 35;  // rounded Q16.16 step
  localparam int SUM_W   = 36;  // position plus step before saturation

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] distance;
    logic [15:0]        turn_amount;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
  } drpu_cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } drpu_pose_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             mul_lo;
    logic             mul_hi;
    logic             step;
    logic             round;
    logic             write;
    logic [IDX_W-1:0] step_idx;
  } drpu_ctl_t;

  // round(atan(2^-i) * 2^24 / 2pi)
  function automatic logic [22:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic [22:0] a;
    case (i)
      5'd0:  a = 23'd2097152;
      5'd1:  a = 23'd1238021;
      5'd2:  a = 23'd654136;
      5'd3:  a = 23'd332050;
      5'd4:  a = 23'd166669;
      5'd5:  a = 23'd83416;
      5'd6:  a = 23'd41718;
      5'd7:  a = 23'd20860;
      5'd8:  a = 23'd10430;
      5'd9:  a = 23'd5215;
      5'd10: a = 23'd2608;
      5'd11: a = 23'd1304;
      5'd12: a = 23'd652;
      5'd13: a = 23'd326;
      5'd14: a = 23'd163;
      5'd15: a = 23'd81;
      5'd16: a = 23'd41;
      5'd17: a = 23'd20;
      5'd18: a = 23'd10;
      5'd19: a = 23'd5;
      5'd20: a = 23'd3;
      5'd21: a = 23'd1;
      5'd22: a = 23'd1;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/drpu_ctrl.sv
`default_nettype none

module drpu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire logic [1:0]           operation,
  output logic                      cmd_stall,
  input  wire logic                 pose_stall,
  output logic                      pose_valid,
  output drpu_pkg::drpu_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULLO = 3'd1;
  localparam logic [2:0] S_MULHI = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;

  logic [2:0]                 state, state_next;
  logic [drpu_pkg::IDX_W-1:0] idx, idx_next;
  logic                       accept, wb_fire, last_step;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign wb_fire   = (state == S_WB) && (!pose_valid || !pose_stall);
  assign last_step = (idx == drpu_pkg::IDX_W'(drpu_pkg::NUM_ITER - 1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (operation == drpu_pkg::OP_MOVE) ? S_MULLO : S_WB;
        end
      end
      S_MULLO: state_next = S_MULHI;
      S_MULHI: begin
        state_next = S_ITER;
        idx_next   = '0;
      end
      S_ITER: begin
        if (last_step) begin
          state_next = S_RND;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_RND: state_next = S_WB;
      S_WB: begin
        if (wb_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.load     = accept;
    ctl.mul_lo   = (state == S_MULLO);
    ctl.mul_hi   = (state == S_MULHI);
    ctl.step     = (state == S_ITER);
    ctl.round    = (state == S_RND);
    ctl.write    = wb_fire;
    ctl.step_idx = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      pose_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (wb_fire) begin
        pose_valid <= 1'b1;
      end else if (!pose_stall) begin
        pose_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/drpu_dpath.sv
`default_nettype none

module drpu_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire drpu_pkg::drpu_ctl_t  ctl,
  input  wire drpu_pkg::drpu_cmd_t  cmd,
  output drpu_pkg::drpu_pose_t      pose
);

  localparam int VW = drpu_pkg::VEC_W;
  localparam int AW = drpu_pkg::ANG_W;
  localparam int DW = drpu_pkg::DELTA_W;
  localparam int SW = drpu_pkg::SUM_W;

  drpu_pkg::drpu_cmd_t     item;
  logic signed [31:0]      cur_x, cur_y;
  logic [15:0]             cur_heading;

  logic signed [47:0]      plo;
  logic signed [VW-1:0]    vx, vy;
  logic signed [AW-1:0]    z;
  logic                    flip;
  logic signed [DW-1:0]    dx, dy;

  logic signed [48:0]      plo_full, phi;
  logic signed [16:0]      h_fold;
  logic signed [VW-1:0]    sx, sy;
  logic signed [AW-1:0]    atan_s;
  logic signed [VW:0]      rx, ry;
  logic signed [SW-1:0]    sum_x, sum_y;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v[SW-1:31] == {(SW-31){1'b0}} || v[SW-1:31] == {(SW-31){1'b1}}) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // gain products, 32 x 17 each
  assign plo_full = {{17{item.distance[31]}}, item.distance} * {33'd0, drpu_pkg::GAIN_LO};
  assign phi      = {{17{item.distance[31]}}, item.distance} * {33'd0, drpu_pkg::GAIN_HI};

  // fold heading into a half turn around zero
  always_comb begin
    h_fold = {cur_heading[15], cur_heading};
    if (h_fold > 17'sd16384) begin
      h_fold = h_fold - 17'sd32768;
    end else if (h_fold < -17'sd16384) begin
      h_fold = h_fold + 17'sd32768;
    end
  end

  assign sx     = vx >>> ctl.step_idx;
  assign sy     = vy >>> ctl.step_idx;
  assign atan_s = AW'(drpu_pkg::atan_entry(drpu_pkg::ATAN_IDX_W'(ctl.step_idx)));

  assign rx = (flip ? -{vx[VW-1], vx} : {vx[VW-1], vx}) + (VW+1)'(32768);
  assign ry = (flip ? -{vy[VW-1], vy} : {vy[VW-1], vy}) + (VW+1)'(32768);

  assign sum_x = {{(SW-32){cur_x[31]}}, cur_x} + {{(SW-DW){dx[DW-1]}}, dx};
  assign sum_y = {{(SW-32){cur_y[31]}}, cur_y} + {{(SW-DW){dy[DW-1]}}, dy};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= cmd;
    end
    if (ctl.mul_lo) begin
      plo <= plo_full[47:0];
    end
    if (ctl.mul_hi) begin
      vx   <= {phi[48], phi} + {{(VW-48){plo[47]}}, (plo >>> 16)};
      vy   <= '0;
      z    <= {{(AW-25){h_fold[16]}}, h_fold, 8'd0};
      flip <= (h_fold != {cur_heading[15], cur_heading});
    end
    if (ctl.step) begin
      if (!z[AW-1]) begin
        vx <= vx - sy;
        vy <= vy + sx;
        z  <= z - atan_s;
      end else begin
        vx <= vx + sy;
        vy <= vy - sx;
        z  <= z + atan_s;
      end
    end
    if (ctl.round) begin
      dx <= rx[VW:16];
      dy <= ry[VW:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      cur_heading <= '0;
    end else if (ctl.write) begin
      case (item.operation)
        drpu_pkg::OP_MOVE: begin
          cur_x <= sat32(sum_x);
          cur_y <= sat32(sum_y);
        end
        drpu_pkg::OP_TURN: cur_heading <= cur_heading + item.turn_amount;
        drpu_pkg::OP_SET: begin
          cur_x       <= item.new_x;
          cur_y       <= item.new_y;
          cur_heading <= item.new_heading;
        end
        default: ;
      endcase
    end
  end

  // pose only changes when the output holds nothing untaken
  assign pose.pos_x   = cur_x;
  assign pose.pos_y   = cur_y;
  assign pose.heading = cur_heading;

endmodule

`default_nettype wire

FILE: design/dead_reckoning_pose_update.sv
// channel | direction | handshake             | payload
// cmd     | in        | cmd_valid/cmd_stall   | drpu_cmd_t  (operation, distance, ...)
// pose    | out       | pose_valid/pose_stall | drpu_pose_t (pos_x, pos_y, heading)
//
// Move: gain multiply in two halves, one micro-rotation per cycle, rounding,
//   write-back. A new item is taken only once the previous one has been written back.
// Turn, set and undefined codes: go from acceptance straight to write-back.
// Reset (rst, synchronous) zeroes the pose and empties the output register.
// A stalled result holds; the next item runs up to write-back and waits there.
`default_nettype none

module dead_reckoning_pose_update (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire drpu_pkg::drpu_cmd_t  cmd,
  output logic                      pose_valid,
  input  wire logic                 pose_stall,
  output drpu_pkg::drpu_pose_t      pose
);

  drpu_pkg::drpu_ctl_t ctl;

  // sequencer: one item at a time, steps the CORDIC, gates write-back
  drpu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .operation  (cmd.operation),
    .cmd_stall  (cmd_stall),
    .pose_stall (pose_stall),
    .pose_valid (pose_valid),
    .ctl        (ctl)
  );

  // pose registers, gain multiply, CORDIC rotator, rounding and saturation
  drpu_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cmd  (cmd),
    .pose (pose)
  );

endmodule

`default_nettype wire

FILE: design/drpu_checker.sv
`default_nettype none
`include "dead_reckoning_pose_update_macros.svh"

module drpu_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cmd_valid,
  input wire logic                 cmd_stall,
  input wire logic                 pose_valid,
  input wire logic                 pose_stall,
  input wire drpu_pkg::drpu_pose_t pose
);

  `DRPU_ASSERT_NEXT(a_pose_hold, clk, rst, pose_valid && pose_stall, pose_valid && $stable(pose), "stalled pose item dropped or changed")
  `DRPU_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall, "second item taken while busy")
  `DRPU_ASSERT_SAME(a_done_has_result, clk, rst, $fell(cmd_stall), pose_valid, "item finished without a result")
  `DRPU_ASSERT_SAME(a_result_from_item, clk, rst, $rose(pose_valid), $past(cmd_stall), "result with no item in flight")

endmodule

bind dead_reckoning_pose_update drpu_checker u_drpu_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .pose_valid (pose_valid),
  .pose_stall (pose_stall),
  .pose       (pose)
);

`default_nettype wire

FILE: dv/dead_reckoning_pose_update_tb.sv
`timescale 1ns / 100ps

module dead_reckoning_pose_update_tb;

  // code the block must treat as a no-op that still returns the pose
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // arctangent steps, 2^24 units per full turn
  localparam longint ATAN_TURN24 [0:23] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };
  localparam longint GAIN_Q32 = 64'sd2608131496;  // 0.60725... in Q0.32
  localparam int     ROT_LIMIT = 24;

  localparam int PHASE_ITEMS = 390;
  localparam int LONG_HOLD   = 300;  // receiver hold-off, cycles
  localparam int TAIL_CYCLES = 30;   // wait after the last drain before the final check

  localparam logic [31:0] DIST_EDGES [0:4] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF
  };
  localparam logic [15:0] HEADING_EDGES [0:5] = '{
    16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hBFFF, 16'hC000
  };

  // ---------------------------------------------------------------------------
  // Pose tracker: keeps its own copy of x, y and heading, works out the pose
  // each accepted command should return and checks results in order.
  // ---------------------------------------------------------------------------
  class pose_predictor;
    longint               x_q;
    longint               y_q;
    logic [15:0]          hdg;
    drpu_pkg::drpu_pose_t pending_poses[$];
    int                   mismatches;

    function new();
      x_q        = 0;
      y_q        = 0;
      hdg        = '0;
      mismatches = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // CORDIC rotation of (d * G, 0) by the heading, folded to +-quarter turn
    function void advance(longint d);
      int     h;
      bit     flip;
      longint vx, vy, z, sx, sy;
      int     n;
      h    = int'(hdg);
      flip = 1'b0;
      if (h >= 32768) h -= 65536;
      if (h > 16384) begin
        h -= 32768;
        flip = 1'b1;
      end else if (h < -16384) begin
        h += 32768;
        flip = 1'b1;
      end
      z  = longint'(h) * 256;
      vx = (d * GAIN_Q32) >>> 16;
      vy = 0;
      n  = (drpu_pkg::CORDIC_STEPS < ROT_LIMIT) ? drpu_pkg::CORDIC_STEPS : ROT_LIMIT;
      for (int i = 0; i < n; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (z >= 0) begin
          vx -= sy;
          vy += sx;
          z  -= ATAN_TURN24[i];
        end else begin
          vx += sy;
          vy -= sx;
          z  += ATAN_TURN24[i];
        end
      end
      if (flip) begin
        vx = -vx;
        vy = -vy;
      end
      x_q = clamp32(x_q + ((vx + 32768) >>> 16));
      y_q = clamp32(y_q + ((vy + 32768) >>> 16));
    endfunction

    function void note_command(drpu_pkg::drpu_cmd_t c);
      drpu_pkg::drpu_pose_t p;
      case (c.operation)
        drpu_pkg::OP_MOVE: advance(longint'(c.distance));
        drpu_pkg::OP_TURN: hdg = hdg + c.turn_amount;
        drpu_pkg::OP_SET: begin
          x_q = longint'(c.new_x);
          y_q = longint'(c.new_y);
          hdg = c.new_heading;
        end
        default: ;
      endcase
      p.pos_x   = x_q[31:0];
      p.pos_y   = y_q[31:0];
      p.heading = hdg;
      pending_poses.push_back(p);
    endfunction

    function void check_pose(drpu_pkg::drpu_pose_t got);
      drpu_pkg::drpu_pose_t want;
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected pose x %0d y %0d heading %0d", $time,
                 got.pos_x, got.pos_y, got.heading);
        mismatches++;
        return;
      end
      want = pending_poses.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.heading !== want.heading) begin
        $display("%0t: heading expected %0d actual %0d", $time, want.heading,
                 got.heading);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  drpu_pkg::drpu_cmd_t  cmd;
  logic                 pose_valid;
  logic                 pose_stall;
  drpu_pkg::drpu_pose_t pose;

  pose_predictor pred = new();

  // percentages for sender gaps and receiver stalls, per phase
  int idle_pct;
  int stall_pct;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_req;

  dead_reckoning_pose_update u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pose_valid(pose_valid),
    .pose_stall(pose_stall),
    .pose      (pose)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Both handshakes sampled on the edge, before any new drive lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) pred.note_command(cmd);
      if (pose_valid && !pose_stall) pred.check_pose(pose);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request, counted here.
  initial begin
    int served;
    served = 0;
    pose_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served = hold_req;
        pose_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      pose_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one item, hold it until taken, then maybe leave a gap.
  // Valid is only lowered for a gap, so back-to-back items keep it high.
  task automatic send_cmd(input drpu_pkg::drpu_cmd_t c);
    int gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      cmd       <= noise_cmd();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding pose.
  task automatic drain_poses();
    if (cmd_valid) cmd_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending_poses.size() != 0) @(posedge clk);
  endtask

  // fields the operation ignores still carry junk
  function automatic drpu_pkg::drpu_cmd_t noise_cmd();
    drpu_pkg::drpu_cmd_t c;
    c.operation   = 2'($urandom_range(3));
    c.distance    = $urandom;
    c.turn_amount = 16'($urandom_range(16'hFFFF));
    c.new_x       = $urandom;
    c.new_y       = $urandom;
    c.new_heading = 16'($urandom_range(16'hFFFF));
    return c;
  endfunction

  task automatic move_by(input logic [31:0] d);
    drpu_pkg::drpu_cmd_t c;
    c           = noise_cmd();
    c.operation = drpu_pkg::OP_MOVE;
    c.distance  = d;
    send_cmd(c);
  endtask

  task automatic turn_by(input logic [15:0] a);
    drpu_pkg::drpu_cmd_t c;
    c             = noise_cmd();
    c.operation   = drpu_pkg::OP_TURN;
    c.turn_amount = a;
    send_cmd(c);
  endtask

  task automatic set_pose(input logic [31:0] x, input logic [31:0] y,
                          input logic [15:0] h);
    drpu_pkg::drpu_cmd_t c;
    c             = noise_cmd();
    c.operation   = drpu_pkg::OP_SET;
    c.new_x       = x;
    c.new_y       = y;
    c.new_heading = h;
    send_cmd(c);
  endtask

  // Mix of small steps, big steps and the range edges.
  function automatic logic [31:0] pick_distance();
    logic [31:0] d;
    case ($urandom_range(3))
      0: d = $urandom;
      1: d = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      2: begin
        d = $urandom | 32'h4000_0000;
        if ($urandom_range(1)) d = ~d;
      end
      default: d = DIST_EDGES[$urandom_range(4)];
    endcase
    return d;
  endfunction

  // Coordinates, often near the Q16.16 limits so that later moves saturate.
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(1)) return 32'h7FFF_FFFF - $urandom_range(32'h00FF_FFFF);
      return 32'h8000_0000 + $urandom_range(32'h00FF_FFFF);
    end
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_heading();
    if ($urandom_range(99) < 20) return HEADING_EDGES[$urandom_range(5)];
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic drpu_pkg::drpu_cmd_t random_cmd();
    drpu_pkg::drpu_cmd_t c;
    int                  r;
    c = noise_cmd();
    r = $urandom_range(99);
    if (r < 45) begin
      c.operation = drpu_pkg::OP_MOVE;
      c.distance  = pick_distance();
    end else if (r < 65) begin
      c.operation   = drpu_pkg::OP_TURN;
      c.turn_amount = ($urandom_range(3) == 0) ? pick_heading()
                                               : 16'($urandom_range(16'hFFFF));
    end else if (r < 90) begin
      c.operation   = drpu_pkg::OP_SET;
      c.new_x       = pick_coord();
      c.new_y       = pick_coord();
      c.new_heading = pick_heading();
    end else begin
      c.operation = OP_RESERVED;
    end
    return c;
  endfunction

  initial begin
    drpu_pkg::drpu_cmd_t c;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    idle_pct  <= 0;
    stall_pct <= 0;
    hold_req  <= 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, no idling ----
    move_by(32'h0001_0000);        // unit step east from reset
    move_by(32'h7FFF_FFFF);        // largest forward step
    move_by(32'h8000_0000);        // largest backward step
    turn_by(16'hFFFF);             // one unit short of a full turn
    turn_by(16'h0001);             // wraps back to zero
    turn_by(16'h4000);             // exactly a quarter turn, no fold
    move_by(32'h0010_0000);
    turn_by(16'h0001);             // just past a quarter: folded and negated
    move_by(32'h0010_0000);
    // x runs into the top limit
    set_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    move_by(32'h7FFF_FFFF);
    // half turn, x runs into the bottom limit
    set_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
    move_by(32'h7FFF_FFFF);
    // minus a quarter exactly, then just beyond it
    set_pose(32'h0000_0000, 32'h8000_0000, 16'hC000);
    move_by(32'h7FFF_FFFF);
    set_pose(32'h0000_0000, 32'h0000_0000, 16'hBFFF);
    move_by(32'h8000_0000);
    set_pose(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
    move_by(32'hFFFF_FFFF);
    // reserved code with every field at all ones
    c             = '1;
    c.operation   = OP_RESERVED;
    send_cmd(c);
    set_pose(32'h0000_0000, 32'h0000_0000, 16'h0000);
    move_by(32'h0000_0000);
    drain_poses();

    // ---- random phases: none, sender gaps, receiver stalls, both ----
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  <= (ph == 1) ? 56 : (ph == 3) ? 17 : 0;
      stall_pct <= (ph == 2) ? 56 : (ph == 3) ? 17 : 0;
      @(posedge clk);
      repeat (PHASE_ITEMS) send_cmd(random_cmd());
      if (ph == 0) begin
        // long receiver hold-off while items keep coming: input must back up
        hold_req <= hold_req + 1;
        repeat (16) send_cmd(random_cmd());
      end
      // sender waits for every outstanding pose before the next phase
      drain_poses();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pred.mismatches == 0 && pred.pending_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
